// ===== rtl/thsafe_pkg.sv =====
`default_nettype none

package thsafe_pkg;

    // operation codes carried in tuser
    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_REQUEST = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    // operating modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_HEAT      = 3'd1;
    localparam logic [2:0] MODE_COOL      = 3'd2;
    localparam logic [2:0] MODE_VIBRATION = 3'd3;
    localparam logic [2:0] MODE_COMBINED  = 3'd4;
    localparam logic [2:0] MODE_FAULT     = 3'd5;

    // fault codes
    localparam logic [1:0] CODE_NONE    = 2'd0;
    localparam logic [1:0] CODE_SENSOR  = 2'd1;
    localparam logic [1:0] CODE_CUTOFF  = 2'd2;
    localparam logic [1:0] CODE_BATTERY = 2'd3;

    // drive duties
    localparam logic [7:0] DUTY_OFF     = 8'd0;
    localparam logic [7:0] DUTY_HIGH    = 8'd190;
    localparam logic [7:0] DUTY_LOW     = 8'd70;
    localparam logic [7:0] DUTY_VIBRATE = 8'd150;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_THERMAL_CUTOFF = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MIN_VALID = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MAX_VALID = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_LOW_MV = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_FLOOR     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_CEILING   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_FLOOR     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL_CEILING   = 4'd7;

    // register reset values
    localparam logic signed [11:0] RST_THERMAL_CUTOFF = 12'sd440;
    localparam logic signed [11:0] RST_TEMP_MIN_VALID = 12'sd50;
    localparam logic signed [11:0] RST_TEMP_MAX_VALID = 12'sd500;
    localparam logic [12:0]        RST_BATTERY_LOW_MV = 13'd3350;
    localparam logic signed [11:0] RST_HEAT_FLOOR     = 12'sd380;
    localparam logic signed [11:0] RST_HEAT_CEILING   = 12'sd420;
    localparam logic signed [11:0] RST_COOL_FLOOR     = 12'sd180;
    localparam logic signed [11:0] RST_COOL_CEILING   = 12'sd220;

    typedef struct packed {
        logic signed [11:0] thermal_cutoff;
        logic signed [11:0] temp_min_valid;
        logic signed [11:0] temp_max_valid;
        logic [12:0]        battery_low_mv;
        logic signed [11:0] heat_floor;
        logic signed [11:0] heat_ceiling;
        logic signed [11:0] cool_floor;
        logic signed [11:0] cool_ceiling;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         requested_mode;
        logic               sensor_valid;
        logic signed [11:0] skin_temp;
        logic [12:0]        battery_mv;
    } t_item;

    typedef struct packed {
        logic [2:0] mode;
        logic       fault_active;
        logic [1:0] fault_code;
    } t_state;

    typedef struct packed {
        logic [7:0] heater_duty;
        logic [7:0] cooler_duty;
        logic [7:0] vibration_duty;
        t_state     state;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/thsafe_cfg.sv =====
`default_nettype none

module thsafe_cfg
    import thsafe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_THERMAL_CUTOFF: n_cfg.thermal_cutoff = i_wr_data[11:0];
                CFG_TEMP_MIN_VALID: n_cfg.temp_min_valid = i_wr_data[11:0];
                CFG_TEMP_MAX_VALID: n_cfg.temp_max_valid = i_wr_data[11:0];
                CFG_BATTERY_LOW_MV: n_cfg.battery_low_mv = i_wr_data;
                CFG_HEAT_FLOOR:     n_cfg.heat_floor     = i_wr_data[11:0];
                CFG_HEAT_CEILING:   n_cfg.heat_ceiling   = i_wr_data[11:0];
                CFG_COOL_FLOOR:     n_cfg.cool_floor     = i_wr_data[11:0];
                CFG_COOL_CEILING:   n_cfg.cool_ceiling   = i_wr_data[11:0];
                default:            n_cfg = r_cfg; // unmapped index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thermal_cutoff <= RST_THERMAL_CUTOFF;
            r_cfg.temp_min_valid <= RST_TEMP_MIN_VALID;
            r_cfg.temp_max_valid <= RST_TEMP_MAX_VALID;
            r_cfg.battery_low_mv <= RST_BATTERY_LOW_MV;
            r_cfg.heat_floor     <= RST_HEAT_FLOOR;
            r_cfg.heat_ceiling   <= RST_HEAT_CEILING;
            r_cfg.cool_floor     <= RST_COOL_FLOOR;
            r_cfg.cool_ceiling   <= RST_COOL_CEILING;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/thsafe_eval.sv =====
`default_nettype none

module thsafe_eval
    import thsafe_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    input  t_state  i_state,
    output t_result o_result
);

    logic   thermal;
    logic   sensor_bad;
    logic   over_cutoff;
    logic   battery_low;
    t_state n_state;
    logic [7:0] heat;
    logic [7:0] cool;
    logic [7:0] vib;

    assign thermal = (i_state.mode == MODE_HEAT) || (i_state.mode == MODE_COOL)
                  || (i_state.mode == MODE_COMBINED);

    assign sensor_bad  = !i_item.sensor_valid
                      || (i_item.skin_temp < i_cfg.temp_min_valid)
                      || (i_item.skin_temp > i_cfg.temp_max_valid);
    assign over_cutoff = i_item.skin_temp >= i_cfg.thermal_cutoff;
    assign battery_low = (i_item.battery_mv < i_cfg.battery_low_mv) && thermal;

    always_comb begin
        n_state = i_state;
        heat    = DUTY_OFF;
        cool    = DUTY_OFF;
        vib     = DUTY_OFF;
        unique case (i_item.operation)
            OP_REQUEST: begin
                if (!i_state.fault_active && (i_item.requested_mode <= MODE_FAULT)) begin
                    n_state.mode = i_item.requested_mode;
                end
            end
            OP_RESET: begin
                n_state.mode         = MODE_IDLE;
                n_state.fault_active = 1'b0;
                n_state.fault_code   = CODE_NONE;
            end
            OP_UPDATE: begin
                // checks in priority order
                priority if (sensor_bad) begin
                    n_state = '{mode: MODE_FAULT, fault_active: 1'b1, fault_code: CODE_SENSOR};
                end else if (over_cutoff) begin
                    n_state = '{mode: MODE_FAULT, fault_active: 1'b1, fault_code: CODE_CUTOFF};
                end else if (battery_low) begin
                    n_state = '{mode: MODE_FAULT, fault_active: 1'b1, fault_code: CODE_BATTERY};
                end else begin
                    n_state = i_state;
                end

                if (!n_state.fault_active) begin
                    if ((i_state.mode == MODE_HEAT) || (i_state.mode == MODE_COMBINED)) begin
                        if (i_item.skin_temp < i_cfg.heat_floor) begin
                            heat = DUTY_HIGH;
                        end else if (i_item.skin_temp < i_cfg.heat_ceiling) begin
                            heat = DUTY_LOW;
                        end
                    end
                    if (i_state.mode == MODE_COOL) begin
                        if (i_item.skin_temp > i_cfg.cool_ceiling) begin
                            cool = DUTY_HIGH;
                        end else if (i_item.skin_temp > i_cfg.cool_floor) begin
                            cool = DUTY_LOW;
                        end
                    end
                    if ((i_state.mode == MODE_VIBRATION) || (i_state.mode == MODE_COMBINED)) begin
                        vib = DUTY_VIBRATE;
                    end
                end
            end
            default: n_state = i_state; // unused operation code
        endcase
    end

    assign o_result.heater_duty    = heat;
    assign o_result.cooler_duty    = cool;
    assign o_result.vibration_duty = vib;
    assign o_result.state          = n_state;

endmodule

`default_nettype wire

// ===== rtl/thermal_safety_mode_controller.sv =====
`default_nettype none

// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+-----------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | tuser operation, tdata item fields
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata duties, mode, fault flag, code
// cfg       | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not blocked; an accepted item passes through the input register,
// then the evaluation logic and the result register before its result is valid
// synchronous active-low reset restores the configuration defaults, idle mode, no fault
// a stalled result register holds and the input register refills behind it, so the
// input side stalls only while both registers are full and the output is blocked
// the configuration port is always ready

module thermal_safety_mode_controller
    import thsafe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input item stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [2:0] requested_mode, [3] sensor_valid, [15:4] skin_temp, [28:16] battery_mv,
    // [31:29] zero
    input  wire logic [31:0]           s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]            s_axis_tuser,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] heater_duty, [15:8] cooler_duty, [23:16] vibration_duty,
    // [26:24] current_mode, [27] fault_active, [29:28] fault_code, [31:30] zero
    output logic [31:0]                m_axis_tdata,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_valid;
    t_state  r_state;
    t_result r_out;
    logic    r_out_valid;
    t_result eval_result;
    logic    out_free;
    logic    advance;

    assign o_cfg_ready = 1'b1;

    thsafe_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // stage handshake: result register free or draining this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.operation      <= s_axis_tuser;
            r_item.requested_mode <= s_axis_tdata[2:0];
            r_item.sensor_valid   <= s_axis_tdata[3];
            r_item.skin_temp      <= s_axis_tdata[15:4];
            r_item.battery_mv     <= s_axis_tdata[28:16];
        end
    end

    thsafe_eval u_eval (
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_result (eval_result)
    );

    // mode, fault latch and code move only when an item leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= MODE_IDLE;
            r_state.fault_active <= 1'b0;
            r_state.fault_code   <= CODE_NONE;
        end else if (advance) begin
            r_state <= eval_result.state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= eval_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.state.fault_code, r_out.state.fault_active,
                            r_out.state.mode, r_out.vibration_duty, r_out.cooler_duty,
                            r_out.heater_duty};

    // a latched fault always forces the fault mode
    a_latch_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.fault_active |-> (r_state.mode == MODE_FAULT))
        else $error("fault latched outside fault mode");

    // latch and code agree
    a_latch_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.fault_active == (r_state.fault_code != CODE_NONE))
        else $error("fault latch and fault code disagree");

    // state holds unless an item is evaluated
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("state changed without an item");

    // a result showing a fault carries no drive
    a_fault_no_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.state.fault_active) |->
            ((r_out.heater_duty == DUTY_OFF) && (r_out.cooler_duty == DUTY_OFF)
             && (r_out.vibration_duty == DUTY_OFF)))
        else $error("duty driven while fault active");

endmodule

`default_nettype wire

// ===== test/thermal_safety_mode_controller_test.sv =====
`default_nettype none

module thermal_safety_mode_controller_test;
    import thsafe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // codes the block must ignore
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [2:0] MODE_UNDEF_LO  = 3'd6;
    localparam logic [2:0] MODE_UNDEF_HI  = 3'd7;

    // cycles with no transaction anywhere before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // idle wait once the queues drain, past the input register and the result register
    localparam int SETTLE_CYCLES = 6;
    localparam int SEGMENTS = 6;
    localparam int SEGMENT_ITEMS = 188;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_UPDATE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_THERMAL_CUTOFF;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    thermal_safety_mode_controller uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the controller: thresholds by register index, mode, latch, code
    int         cfg_val[8];
    logic [2:0] ctl_mode = MODE_IDLE;
    logic       ctl_fault = 1'b0;
    logic [1:0] ctl_code = CODE_NONE;

    t_item   pending_items[$];      // items waiting for the driver
    t_result expected_results[$];   // predicted results, oldest first
    t_item   held_item;             // item currently offered on the input
    t_result want;

    int src_idle_pct = 32;
    int snk_idle_pct = 70;
    int mismatches = 0;
    int stall_cycles = 0;
    int queued_items = 0;

    function automatic void latch_fault(logic [1:0] code);
        ctl_fault = 1'b1;
        ctl_code  = code;
        ctl_mode  = MODE_FAULT;
    endfunction

    // one item through the shadow controller, returns the result it must produce
    function automatic t_result advance_controller(t_item it);
        t_result res;
        int      temp;
        logic    thermal;
        res = '0;
        temp = int'($signed(it.skin_temp));
        case (it.operation)
            OP_REQUEST: begin
                // requests are locked out while a fault is latched
                if (!ctl_fault && it.requested_mode <= MODE_FAULT)
                    ctl_mode = it.requested_mode;
            end
            OP_RESET: begin
                ctl_fault = 1'b0;
                ctl_code  = CODE_NONE;
                ctl_mode  = MODE_IDLE;
            end
            OP_UPDATE: begin
                thermal = (ctl_mode == MODE_HEAT) || (ctl_mode == MODE_COOL) ||
                          (ctl_mode == MODE_COMBINED);
                // checks in priority order, a later trip overwrites an older code
                if (!it.sensor_valid || temp < cfg_val[CFG_TEMP_MIN_VALID] ||
                    temp > cfg_val[CFG_TEMP_MAX_VALID])
                    latch_fault(CODE_SENSOR);
                else if (temp >= cfg_val[CFG_THERMAL_CUTOFF])
                    latch_fault(CODE_CUTOFF);
                else if (int'(it.battery_mv) < cfg_val[CFG_BATTERY_LOW_MV] && thermal)
                    latch_fault(CODE_BATTERY);
                if (!ctl_fault) begin
                    if (ctl_mode == MODE_HEAT || ctl_mode == MODE_COMBINED)
                        res.heater_duty = temp < cfg_val[CFG_HEAT_FLOOR]   ? DUTY_HIGH :
                                          temp < cfg_val[CFG_HEAT_CEILING] ? DUTY_LOW : DUTY_OFF;
                    if (ctl_mode == MODE_COOL)
                        res.cooler_duty = temp > cfg_val[CFG_COOL_CEILING] ? DUTY_HIGH :
                                          temp > cfg_val[CFG_COOL_FLOOR]   ? DUTY_LOW : DUTY_OFF;
                    if (ctl_mode == MODE_VIBRATION || ctl_mode == MODE_COMBINED)
                        res.vibration_duty = DUTY_VIBRATE;
                end
            end
            default: ;
        endcase
        res.state.mode         = ctl_mode;
        res.state.fault_active = ctl_fault;
        res.state.fault_code   = ctl_code;
        return res;
    endfunction

    task automatic check_field(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t %s: expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // input driver: offers the next pending item when the slot is free, idling at random per src_idle_pct
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(advance_controller(held_item));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    held_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, held_item.battery_mv, held_item.skin_temp,
                                      held_item.sensor_valid, held_item.requested_mode};
                    s_axis_tuser  <= held_item.operation;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t result: expected none, got %h", $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("heater_duty", int'(want.heater_duty),
                                int'(m_axis_tdata[7:0]));
                    check_field("cooler_duty", int'(want.cooler_duty),
                                int'(m_axis_tdata[15:8]));
                    check_field("vibration_duty", int'(want.vibration_duty),
                                int'(m_axis_tdata[23:16]));
                    check_field("current_mode", int'(want.state.mode),
                                int'(m_axis_tdata[26:24]));
                    check_field("fault_active", int'(want.state.fault_active),
                                int'(m_axis_tdata[27]));
                    check_field("fault_code", int'(want.state.fault_code),
                                int'(m_axis_tdata[29:28]));
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // threshold writes go into the shadow at the config transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BATTERY_LOW_MV:
                    cfg_val[CFG_BATTERY_LOW_MV] = int'(i_cfg_data);
                CFG_THERMAL_CUTOFF, CFG_TEMP_MIN_VALID, CFG_TEMP_MAX_VALID, CFG_HEAT_FLOOR,
                CFG_HEAT_CEILING, CFG_COOL_FLOOR, CFG_COOL_CEILING:
                    cfg_val[i_cfg_index[2:0]] = int'($signed(i_cfg_data[11:0]));
                default: ;  // unmapped index, no effect
            endcase
        end
    end

    // hang detection
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic push(logic [1:0] op, logic [2:0] req, logic valid, logic [11:0] temp,
                        logic [12:0] batt);
        t_item it;
        it.operation      = op;
        it.requested_mode = req;
        it.sensor_valid   = valid;
        it.skin_temp      = temp;
        it.battery_mv     = batt;
        pending_items.push_back(it);
        if (op != OP_UNUSED)
            queued_items++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // signed thresholds with the unused top data bit toggled at random
    task automatic write_temp(logic [CFG_IDX_W-1:0] idx, int value);
        write_reg(idx, {1'($urandom_range(0, 1)), 12'(value)});
    endtask

    // kind 0 typical, 1 everything at the low end, 2 wide open with high battery floor,
    // otherwise random ordered thresholds
    task automatic load_setting(int kind);
        int lo;
        int hi;
        int hf;
        int cf;
        case (kind)
            0: begin
                write_temp(CFG_THERMAL_CUTOFF, 400);
                write_temp(CFG_TEMP_MIN_VALID, 0);
                write_temp(CFG_TEMP_MAX_VALID, 600);
                write_reg(CFG_BATTERY_LOW_MV, 13'd3600);
                write_temp(CFG_HEAT_FLOOR, 300);
                write_temp(CFG_HEAT_CEILING, 350);
                write_temp(CFG_COOL_FLOOR, 100);
                write_temp(CFG_COOL_CEILING, 250);
            end
            1: begin
                write_temp(CFG_THERMAL_CUTOFF, -400);
                write_temp(CFG_TEMP_MIN_VALID, -400);
                write_temp(CFG_TEMP_MAX_VALID, -400);
                write_reg(CFG_BATTERY_LOW_MV, 13'd0);
                write_temp(CFG_HEAT_FLOOR, -400);
                write_temp(CFG_HEAT_CEILING, -400);
                write_temp(CFG_COOL_FLOOR, -400);
                write_temp(CFG_COOL_CEILING, -400);
            end
            2: begin
                write_temp(CFG_THERMAL_CUTOFF, 1250);
                write_temp(CFG_TEMP_MIN_VALID, -400);
                write_temp(CFG_TEMP_MAX_VALID, 1250);
                write_reg(CFG_BATTERY_LOW_MV, 13'd6000);
                write_temp(CFG_HEAT_FLOOR, -400);
                write_temp(CFG_HEAT_CEILING, 1250);
                write_temp(CFG_COOL_FLOOR, -400);
                write_temp(CFG_COOL_CEILING, 1250);
            end
            default: begin
                lo = -400 + int'($urandom_range(0, 800));
                hi = lo + int'($urandom_range(100, 1250 - lo));
                hf = lo + int'($urandom_range(0, hi - lo));
                cf = lo + int'($urandom_range(0, hi - lo));
                write_temp(CFG_THERMAL_CUTOFF, lo + int'($urandom_range(0, hi - lo + 50)));
                write_temp(CFG_TEMP_MIN_VALID, lo);
                write_temp(CFG_TEMP_MAX_VALID, hi);
                write_reg(CFG_BATTERY_LOW_MV, 13'($urandom_range(0, 6000)));
                write_temp(CFG_HEAT_FLOOR, hf);
                write_temp(CFG_HEAT_CEILING, hf + int'($urandom_range(0, 100)));
                write_temp(CFG_COOL_FLOOR, cf);
                write_temp(CFG_COOL_CEILING, cf + int'($urandom_range(0, 100)));
            end
        endcase
        // an index past the register file must change nothing
        write_reg(CFG_IDX_W'($urandom_range(CFG_COOL_CEILING + 1, 15)),
                  CFG_DATA_W'($urandom_range(0, 8191)));
    endtask

    // temperatures cluster on the current thresholds so every compare flips
    function automatic logic [11:0] pick_temp();
        int r;
        int lo;
        int hi;
        r = $urandom_range(0, 99);
        lo = cfg_val[CFG_TEMP_MIN_VALID];
        hi = cfg_val[CFG_TEMP_MAX_VALID];
        if (hi < lo) begin
            lo = -400;
            hi = 1250;
        end
        if (r < 55)
            return 12'(cfg_val[$urandom_range(0, 7)] + int'($urandom_range(0, 8)) - 4);
        else if (r < 90)
            return 12'(lo + int'($urandom_range(0, hi - lo)));
        else
            return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [12:0] pick_batt();
        int r;
        int b;
        r = $urandom_range(0, 99);
        if (r < 70)
            b = cfg_val[CFG_BATTERY_LOW_MV] + int'($urandom_range(0, 2000));
        else if (r < 85)
            b = cfg_val[CFG_BATTERY_LOW_MV] + int'($urandom_range(0, 4)) - 2;
        else
            b = $urandom_range(0, 8191);
        if (b < 0)
            b = 0;
        if (b > 8191)
            b = 8191;
        return 13'(b);
    endfunction

    // mostly: optional fault reset, a mode request, a burst of telemetry
    task automatic queue_session();
        logic [2:0] req;
        if ($urandom_range(0, 99) < 10) begin
            // noise, including the unused operation code
            repeat ($urandom_range(1, 3))
                push(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                     13'($urandom_range(0, 8191)));
            return;
        end
        if ($urandom_range(0, 1))
            push(OP_RESET, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                 12'($urandom_range(0, 4095)), 13'($urandom_range(0, 8191)));
        if ($urandom_range(0, 19) == 0)
            req = $urandom_range(0, 1) ? MODE_UNDEF_LO : MODE_UNDEF_HI;
        else
            req = 3'($urandom_range(MODE_IDLE, MODE_FAULT));
        push(OP_REQUEST, req, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
             13'($urandom_range(0, 8191)));
        repeat ($urandom_range(1, 6))
            push(OP_UPDATE, 3'($urandom_range(0, 7)), $urandom_range(0, 19) != 0,
                 pick_temp(), pick_batt());
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        cfg_val[CFG_THERMAL_CUTOFF] = int'(RST_THERMAL_CUTOFF);
        cfg_val[CFG_TEMP_MIN_VALID] = int'(RST_TEMP_MIN_VALID);
        cfg_val[CFG_TEMP_MAX_VALID] = int'(RST_TEMP_MAX_VALID);
        cfg_val[CFG_BATTERY_LOW_MV] = int'(RST_BATTERY_LOW_MV);
        cfg_val[CFG_HEAT_FLOOR]     = int'(RST_HEAT_FLOOR);
        cfg_val[CFG_HEAT_CEILING]   = int'(RST_HEAT_CEILING);
        cfg_val[CFG_COOL_FLOOR]     = int'(RST_COOL_FLOOR);
        cfg_val[CFG_COOL_CEILING]   = int'(RST_COOL_CEILING);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass on the reset thresholds
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(300), 13'(4000));    // idle, all off
        push(OP_REQUEST, MODE_HEAT, 1'b0, '0, '0);
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(379), 13'(4000));    // heater high
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(380), 13'(4000));    // heater low at the floor
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(420), 13'(4000));    // heater off at the ceiling
        push(OP_REQUEST, MODE_COOL, 1'b1, '0, '0);
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(221), 13'(4000));    // cooler high
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(180), 13'(4000));    // cooler off at the floor
        push(OP_REQUEST, MODE_VIBRATION, 1'b0, '0, '0);
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(50), '0);            // no battery check, vibration
        push(OP_REQUEST, MODE_COMBINED, 1'b0, '0, '0);
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(300), 13'(3350));    // heater and vibrator
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(300), 13'(3349));    // low battery in thermal mode
        push(OP_REQUEST, MODE_HEAT, 1'b1, '0, '0);                // locked out by the latch
        push(OP_UPDATE, MODE_IDLE, 1'b0, 12'(300), 13'(8191));    // sensor code overwrites
        push(OP_RESET, MODE_UNDEF_HI, 1'b1, 12'(-1), 13'(8191));
        push(OP_REQUEST, MODE_FAULT, 1'b0, '0, '0);               // fault mode with no latch
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(300), 13'(6000));    // duties stay off
        push(OP_REQUEST, MODE_UNDEF_HI, 1'b1, '0, '0);            // undefined modes hold
        push(OP_REQUEST, MODE_UNDEF_LO, 1'b1, '0, '0);
        push(OP_UNUSED, MODE_HEAT, 1'b1, 12'(-2048), 13'(8191));  // unused operation
        push(OP_RESET, MODE_IDLE, 1'b0, '0, '0);
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(440), 13'(4000));    // cutoff
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(501), 13'(4000));    // above plausible range
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(-2048), '0);         // most negative reading
        push(OP_RESET, MODE_IDLE, 1'b1, 12'(2047), '0);
        push(OP_UPDATE, MODE_IDLE, 1'b1, 12'(2047), 13'(8191));   // most positive reading
        wait_idle();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // first two segments slow receiver, next two slow sender, last two flat out
            if (seg < 2) begin
                src_idle_pct = 32;
                snk_idle_pct = 70;
            end else if (seg < 4) begin
                src_idle_pct = 70;
                snk_idle_pct = 32;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            load_setting(seg);
            queued_items = 0;
            while (queued_items < SEGMENT_ITEMS)
                queue_session();
            wait_idle();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/thsafe_pkg.sv
rtl/thsafe_cfg.sv
rtl/thsafe_eval.sv
rtl/thermal_safety_mode_controller.sv
test/thermal_safety_mode_controller_test.sv
